[sv/linear_blend_skin_point_2d_unit_macros.svh]
// Assertion macros shared by the checker.
// Every macro samples on posedge clk and is disabled while rst_n is low.
`ifndef LINEAR_BLEND_SKIN_POINT_2D_UNIT_MACROS_SVH
`define LINEAR_BLEND_SKIN_POINT_2D_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// Types, constants and fixed-point helpers for the 2D skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SKIN = 1'b1
    } op_t;

    // Configuration register indexes
    localparam logic [2:0] REG_WORLD_XX = 3'd0;
    localparam logic [2:0] REG_WORLD_YX = 3'd1;
    localparam logic [2:0] REG_WORLD_XY = 3'd2;
    localparam logic [2:0] REG_WORLD_YY = 3'd3;
    localparam logic [2:0] REG_WORLD_TX = 3'd4;
    localparam logic [2:0] REG_WORLD_TY = 3'd5;

    localparam int WORDS_PER_BONE = 6;
    localparam int INFLUENCES     = 4;
    localparam int FIFO_DEPTH     = 4;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    // Per-cycle control sent with every table read to the lanes
    typedef struct packed {
        logic        act;     // issue slot carries an item
        logic        use_w;   // influence contributes
        logic        first;   // first influence of the item
        logic        last;    // last influence of the item
        logic [16:0] weight;
    } rd_ctl_t;

    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] radius_out;
    } res_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] radius;
    } pt_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // floor((p + q) / 2^16) + t, saturated
    function automatic logic signed [31:0] affine_sum(input logic signed [63:0] p,
                                                      input logic signed [63:0] q,
                                                      input logic signed [31:0] t);
        logic signed [64:0] s;
        logic signed [64:0] sh;
        logic signed [63:0] r;
        s  = {p[63], p} + {q[63], q};
        sh = s >>> 16;
        r  = sh[63:0] + {{32{t[31]}}, t};
        return sat32(r);
    endfunction

endpackage

[sv/lbs_if.sv]
// ----------------------------------------------------------------------------
// lbs_in_if / lbs_out_if
// Valid/ready request channels of the skinning unit.
// ----------------------------------------------------------------------------
interface lbs_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [8:0]         table_address;
    logic signed [31:0] table_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [23:0]        bone_indices;
    logic [16:0]        weight_0;
    logic [16:0]        weight_1;
    logic [16:0]        weight_2;
    logic [16:0]        weight_3;
    logic signed [31:0] radius;

    modport source (output valid, opcode, table_address, table_value, point_x, point_y,
                    bone_indices, weight_0, weight_1, weight_2, weight_3, radius,
                    input ready);
    modport sink (input valid, opcode, table_address, table_value, point_x, point_y,
                  bone_indices, weight_0, weight_1, weight_2, weight_3, radius,
                  output ready);
endinterface

interface lbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;
    logic signed [31:0] radius_out;

    modport source (output valid, skinned_x, skinned_y, radius_out, input ready);
    modport sink (input valid, skinned_x, skinned_y, radius_out, output ready);
endinterface

[sv/lbs_ram.sv]
// ----------------------------------------------------------------------------
// lbs_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/lbs_lane.sv]
// ----------------------------------------------------------------------------
// lbs_lane
// One matrix-element lane: table slice, weight multiply, blend accumulate.
// ----------------------------------------------------------------------------
module lbs_lane #(
    parameter int BONE_COUNT = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [((BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1)-1:0] waddr,
    input  logic [31:0]              wdata,
    input  logic [((BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1)-1:0] raddr,
    input  lbs_pkg::rd_ctl_t         ctl,
    output logic signed [31:0]       m_out,
    output logic                     m_valid
);

    logic [31:0]              rdata;
    lbs_pkg::rd_ctl_t         ctl_d1_reg;
    lbs_pkg::rd_ctl_t         ctl_d2_reg;
    logic signed [49:0]       prod_reg;
    logic signed [49:0]       prod_next;
    logic signed [51:0]       acc_reg;
    logic signed [51:0]       acc_next;
    logic signed [51:0]       acc_sh;
    logic signed [31:0]       m_reg;
    logic                     m_valid_reg;

    lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Weighted word, zero for a skipped influence
    always_comb
    begin
        if (ctl_d1_reg.use_w)
            prod_next = $signed(rdata) * $signed({1'b0, ctl_d1_reg.weight});
        else
            prod_next = '0;
    end

    // Running blend sum
    always_comb
    begin
        if (ctl_d2_reg.first)
            acc_next = {{2{prod_reg[49]}}, prod_reg};
        else
            acc_next = acc_reg + {{2{prod_reg[49]}}, prod_reg};
        acc_sh = acc_next >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d1_reg  <= '0;
            ctl_d2_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_d1_reg  <= ctl;
            ctl_d2_reg  <= ctl_d1_reg;
            m_valid_reg <= ctl_d2_reg.act && ctl_d2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl_d2_reg.act)
        begin
            acc_reg <= acc_next;
        end
        if (ctl_d2_reg.act && ctl_d2_reg.last)
        begin
            m_reg <= lbs_pkg::sat32({{12{acc_sh[51]}}, acc_sh});
        end
    end

    assign m_out   = m_reg;
    assign m_valid = m_valid_reg;

endmodule

[sv/lbs_merge.sv]
// ----------------------------------------------------------------------------
// lbs_merge
// Applies the blended matrix from the six lanes to the world-mapped point.
// ----------------------------------------------------------------------------
module lbs_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] m [6],
    input  lbs_pkg::pt_t       pt,
    output logic               res_valid,
    output lbs_pkg::res_t      res
);

    logic signed [63:0] px0_reg;
    logic signed [63:0] px1_reg;
    logic signed [63:0] py0_reg;
    logic signed [63:0] py1_reg;
    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    logic signed [31:0] rad_reg;
    logic               s1_valid_reg;
    logic               res_valid_reg;
    lbs_pkg::res_t      res_reg;
    lbs_pkg::res_t      res_next;

    // Second stage: row sums and saturation
    always_comb
    begin
        res_next.skinned_x  = lbs_pkg::affine_sum(px0_reg, px1_reg, tx_reg);
        res_next.skinned_y  = lbs_pkg::affine_sum(py0_reg, py1_reg, ty_reg);
        res_next.radius_out = rad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            res_valid_reg <= s1_valid_reg;
        end
    end

    // First stage: four products, element order xx, yx, xy, yy, tx, ty
    always_ff @(posedge clk)
    begin
        px0_reg <= m[0] * pt.px;
        px1_reg <= m[2] * pt.py;
        py0_reg <= m[1] * pt.px;
        py1_reg <= m[3] * pt.py;
        tx_reg  <= m[4];
        ty_reg  <= m[5];
        rad_reg <= pt.radius;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[sv/linear_blend_skin_point_2d_unit.sv]
// ----------------------------------------------------------------------------
// linear_blend_skin_point_2d_unit
// 2D linear blend skinning of one point with four bone influences.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes requests: a load (opcode 0) writes one bone table word and
//   gives no result; a skin request (opcode 1) gives one result.
//   out_ch delivers skinned_x, skinned_y and radius_out in request order.
//   The APB port writes the world matrix; write it only while idle.
// Timing:
//   A skin request occupies the table read ports, reading one bone per cycle on
//   all six element lanes; the next request can be taken with its last read.
//   Its result passes the RAM, lane and merge registers, then the output queue.
//   Loads need only a free read sequencer and room in the in-flight count.
// Reset:
//   rst_n clears control and loads the identity world matrix. The bone table
//   is not cleared; a bone must be loaded before it is used.
// Stalls:
//   Results queue in a 4-entry output buffer; in_ch drops ready once four skin
//   requests are in flight or queued, so nothing is lost while out_ch stalls.
// ----------------------------------------------------------------------------
module linear_blend_skin_point_2d_unit #(
    parameter int BONE_COUNT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    lbs_in_if.sink             in_ch,
    lbs_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW          = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int TABLE_WORDS = BONE_COUNT * lbs_pkg::WORDS_PER_BONE;
    localparam logic [1:0] LAST_SLOT = 2'(lbs_pkg::INFLUENCES - 1);

    // World matrix registers
    logic signed [31:0] wxx_reg, wyx_reg, wxy_reg, wyy_reg, wtx_reg, wty_reg;
    logic               cfg_wr;

    // Item and sequencer state
    logic               busy_reg;
    logic [1:0]         cnt_reg;
    logic signed [31:0] pt_x_reg, pt_y_reg, rad_reg;
    logic [23:0]        idx_reg;
    logic [16:0]        w_reg [4];
    logic [2:0]         inflight_reg;
    logic [2:0]         inflight_next;

    // World map pipeline
    logic signed [63:0] wp_reg [4];
    logic signed [31:0] px_reg, py_reg;

    logic               free;
    logic               in_acc;
    logic               skin_acc;
    logic               load_acc;
    logic               out_acc;
    logic               last_issue;

    // Load decode
    logic [18:0]        div_prod;
    logic [6:0]         ld_bone;
    logic [8:0]         ld_diff;
    logic [2:0]         ld_elem;
    logic               ld_in_range;
    logic [AW+6:0]      ld_bone_ext;
    logic [AW-1:0]      waddr;

    // Read issue
    logic [5:0]         rd_bone;
    logic [AW+5:0]      rd_bone_ext;
    logic [AW-1:0]      raddr;
    logic [16:0]        rd_w;
    lbs_pkg::rd_ctl_t   ctl;

    // Lanes and merge
    logic signed [31:0] m [6];
    logic               m_valid [6];
    lbs_pkg::pt_t       q1_reg, q2_reg, q3_reg;
    logic               res_valid;
    lbs_pkg::res_t      res;

    // Output queue
    lbs_pkg::res_t      fifo_mem [lbs_pkg::FIFO_DEPTH];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]         fifo_cnt_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wxx_reg <= lbs_pkg::ONE_Q16;
            wyx_reg <= '0;
            wxy_reg <= '0;
            wyy_reg <= lbs_pkg::ONE_Q16;
            wtx_reg <= '0;
            wty_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                lbs_pkg::REG_WORLD_XX: wxx_reg <= pwdata;
                lbs_pkg::REG_WORLD_YX: wyx_reg <= pwdata;
                lbs_pkg::REG_WORLD_XY: wxy_reg <= pwdata;
                lbs_pkg::REG_WORLD_YY: wyy_reg <= pwdata;
                lbs_pkg::REG_WORLD_TX: wtx_reg <= pwdata;
                lbs_pkg::REG_WORLD_TY: wty_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            lbs_pkg::REG_WORLD_XX: prdata = wxx_reg;
            lbs_pkg::REG_WORLD_YX: prdata = wyx_reg;
            lbs_pkg::REG_WORLD_XY: prdata = wxy_reg;
            lbs_pkg::REG_WORLD_YY: prdata = wyy_reg;
            lbs_pkg::REG_WORLD_TX: prdata = wtx_reg;
            lbs_pkg::REG_WORLD_TY: prdata = wty_reg;
            default:               prdata = '0;
        endcase
    end

    // ---------------- request handshake ----------------
    assign last_issue  = busy_reg && (cnt_reg == LAST_SLOT);
    assign free        = !busy_reg || last_issue;
    assign in_ch.ready = free && (inflight_reg < 3'(lbs_pkg::FIFO_DEPTH));
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign skin_acc    = in_acc && (in_ch.opcode == lbs_pkg::OP_SKIN);
    assign load_acc    = in_acc && (in_ch.opcode == lbs_pkg::OP_LOAD);
    assign out_acc     = out_ch.valid && out_ch.ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (skin_acc && !out_acc)
            inflight_next = inflight_reg + 3'd1;
        else if (!skin_acc && out_acc)
            inflight_next = inflight_reg - 3'd1;
    end

    // ---------------- load address split: bone = addr / 6 ----------------
    always_comb
    begin
        div_prod    = 19'(in_ch.table_address) * 19'd683;
        ld_bone     = div_prod[18:12];
        ld_diff     = in_ch.table_address - ({2'b0, ld_bone} << 2) - ({2'b0, ld_bone} << 1);
        ld_elem     = ld_diff[2:0];
        ld_in_range = {2'b0, in_ch.table_address} < 11'(TABLE_WORDS);
        ld_bone_ext = {{AW{1'b0}}, ld_bone};
        waddr       = ld_bone_ext[AW-1:0];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (skin_acc)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (last_issue)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skin_acc)
        begin
            pt_x_reg <= in_ch.point_x;
            pt_y_reg <= in_ch.point_y;
            rad_reg  <= in_ch.radius;
            idx_reg  <= in_ch.bone_indices;
            w_reg[0] <= in_ch.weight_0;
            w_reg[1] <= in_ch.weight_1;
            w_reg[2] <= in_ch.weight_2;
            w_reg[3] <= in_ch.weight_3;
        end
    end

    // ---------------- world map: products, then row sums ----------------
    always_ff @(posedge clk)
    begin
        wp_reg[0] <= wxx_reg * pt_x_reg;
        wp_reg[1] <= wxy_reg * pt_y_reg;
        wp_reg[2] <= wyx_reg * pt_x_reg;
        wp_reg[3] <= wyy_reg * pt_y_reg;
        px_reg    <= lbs_pkg::affine_sum(wp_reg[0], wp_reg[1], wtx_reg);
        py_reg    <= lbs_pkg::affine_sum(wp_reg[2], wp_reg[3], wty_reg);
    end

    // ---------------- read issue, one influence per cycle ----------------
    always_comb
    begin
        case (cnt_reg)
            2'd0:    rd_bone = idx_reg[5:0];
            2'd1:    rd_bone = idx_reg[11:6];
            2'd2:    rd_bone = idx_reg[17:12];
            default: rd_bone = idx_reg[23:18];
        endcase
        rd_w        = w_reg[cnt_reg];
        rd_bone_ext = {{AW{1'b0}}, rd_bone};
        raddr       = rd_bone_ext[AW-1:0];
        ctl.act     = busy_reg;
        ctl.use_w   = (rd_w != '0) && ({3'b0, rd_bone} < 9'(BONE_COUNT));
        ctl.first   = (cnt_reg == 2'd0);
        ctl.last    = (cnt_reg == LAST_SLOT);
        ctl.weight  = rd_w;
    end

    // ---------------- element lanes ----------------
    for (genvar g = 0; g < lbs_pkg::WORDS_PER_BONE; g++)
    begin : g_lane
        lbs_lane #(.BONE_COUNT(BONE_COUNT)) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .we      (load_acc && ld_in_range && (ld_elem == 3'(g))),
            .waddr   (waddr),
            .wdata   (in_ch.table_value),
            .raddr   (raddr),
            .ctl     (ctl),
            .m_out   (m[g]),
            .m_valid (m_valid[g])
        );
    end

    // Point and radius follow the lanes' three-stage latency
    always_ff @(posedge clk)
    begin
        if (last_issue)
        begin
            q1_reg.px     <= px_reg;
            q1_reg.py     <= py_reg;
            q1_reg.radius <= rad_reg;
        end
        q2_reg <= q1_reg;
        q3_reg <= q2_reg;
    end

    lbs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid[0]),
        .m         (m),
        .pt        (q3_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // ---------------- output queue ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (res_valid)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            if (res_valid && !out_acc)
                fifo_cnt_reg <= fifo_cnt_reg + 3'd1;
            else if (!res_valid && out_acc)
                fifo_cnt_reg <= fifo_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    assign out_ch.valid      = (fifo_cnt_reg != '0);
    assign out_ch.skinned_x  = fifo_mem[rd_ptr_reg].skinned_x;
    assign out_ch.skinned_y  = fifo_mem[rd_ptr_reg].skinned_y;
    assign out_ch.radius_out = fifo_mem[rd_ptr_reg].radius_out;

endmodule

[sv/lbs_checker.sv]
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level assertions for the skinning unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_blend_skin_point_2d_unit_macros.svh"

module lbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_radius,
    input logic        pready
);

    // A stalled result stays offered
    `LBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A stalled result keeps its payload
    `LBS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(out_x) && $stable(out_y) && $stable(out_radius), "result changed while stalled")

    // A skin request holds the table reads, so no request is taken next cycle
    `LBS_ASSERT_NEXT(a_skin_busy, in_valid && in_ready && (in_opcode == lbs_pkg::OP_SKIN),
        !in_ready, "request taken during bone reads")

    // Configuration port never waits
    `LBS_ASSERT_SAME(a_pready, 1'b1, pready, "pready low")

endmodule

bind linear_blend_skin_point_2d_unit lbs_checker u_lbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_opcode  (in_ch.opcode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_x      (out_ch.skinned_x),
    .out_y      (out_ch.skinned_y),
    .out_radius (out_ch.radius_out),
    .pready     (pready)
);

[sim/tb_linear_blend_skin_point_2d_unit.sv]
// ----------------------------------------------------------------------------
// tb_linear_blend_skin_point_2d_unit
// Self-checking bench: bone table loads and skin requests are pushed through
// the unit under random idling on both channels, and every skin result is
// compared against an in-bench fixed-point predictor. The world matrix is
// reprogrammed over APB between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_linear_blend_skin_point_2d_unit;

    localparam int BONES     = 64;
    localparam int TBL_WORDS = BONES * lbs_pkg::WORDS_PER_BONE;
    localparam int CYC_LIMIT = 1500000;

    typedef struct packed {
        logic               opcode;
        logic [8:0]         table_address;
        logic signed [31:0] table_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [23:0]        bone_indices;
        logic [16:0]        weight_0;
        logic [16:0]        weight_1;
        logic [16:0]        weight_2;
        logic [16:0]        weight_3;
        logic signed [31:0] radius;
    } req_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lbs_in_if  in_ch();
    lbs_out_if out_ch();

    linear_blend_skin_point_2d_unit #(.BONE_COUNT(BONES)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic signed [31:0] world_m [6];
    logic signed [31:0] bone_words [TBL_WORDS];
    bit                 bone_loaded [BONES];

    req_t          pending_reqs[$];
    lbs_pkg::res_t expected_pts[$];
    int   n_errors;
    int   n_skins;
    int   n_loads;
    int   n_results;
    int   cycles;
    bit   burst_mode;

    // ---------------------------------------------------------------- clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------ fixed-point math
    function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -80'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor((a*b + c*d) / 2^16) + t, saturated
    function automatic logic signed [31:0] map_row(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic signed [31:0] c,
                                                   input logic signed [31:0] d,
                                                   input logic signed [31:0] t);
        logic signed [79:0] s;
        s = 80'(a) * 80'(b) + 80'(c) * 80'(d);
        s = (s >>> 16) + 80'(t);
        return clamp32(s);
    endfunction

    function automatic lbs_pkg::res_t skin_point(input req_t r);
        logic signed [79:0] acc [6];
        logic signed [31:0] blend [6];
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic [16:0]        w;
        logic [5:0]         bone;
        lbs_pkg::res_t      o;
        wx = map_row(world_m[0], r.point_x, world_m[2], r.point_y, world_m[4]);
        wy = map_row(world_m[1], r.point_x, world_m[3], r.point_y, world_m[5]);
        for (int k = 0; k < 6; k++)
            acc[k] = '0;
        for (int i = 0; i < lbs_pkg::INFLUENCES; i++)
        begin
            bone = r.bone_indices[6*i +: 6];
            case (i)
                0: w = r.weight_0;
                1: w = r.weight_1;
                2: w = r.weight_2;
                default: w = r.weight_3;
            endcase
            if (w != 0 && bone < BONES)
                for (int k = 0; k < 6; k++)
                    acc[k] += 80'(bone_words[bone*6 + k]) * 80'(signed'({1'b0, w}));
        end
        for (int k = 0; k < 6; k++)
            blend[k] = clamp32(acc[k] >>> 16);
        o.skinned_x  = map_row(blend[0], wx, blend[2], wy, blend[4]);
        o.skinned_y  = map_row(blend[1], wx, blend[3], wy, blend[5]);
        o.radius_out = r.radius;
        return o;
    endfunction

    // ------------------------------------------------------ request builders
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sd65536;
            3: return -32'sd65536;
            4: return signed'(32'($urandom_range(0, 262143)) - 32'd131072);
            default: return signed'($urandom());
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return 17'($urandom());
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic req_t load_req(input int addr, input logic signed [31:0] v);
        req_t r;
        r = '0;
        r.point_x = signed'($urandom());
        r.bone_indices = 24'($urandom());
        r.opcode = lbs_pkg::OP_LOAD;
        r.table_address = 9'(addr);
        r.table_value = v;
        return r;
    endfunction

    // point + weights + loaded bones; unloaded in-range bones get weight zero
    function automatic req_t skin_req(input logic [23:0] idx, input logic [16:0] w0,
                                      input logic [16:0] w1, input logic [16:0] w2,
                                      input logic [16:0] w3);
        req_t r;
        logic [5:0] b;
        r.opcode        = lbs_pkg::OP_SKIN;
        r.table_address = 9'($urandom());
        r.table_value   = signed'($urandom());
        r.point_x       = rand_word();
        r.point_y       = rand_word();
        r.bone_indices  = idx;
        r.weight_0      = w0;
        r.weight_1      = w1;
        r.weight_2      = w2;
        r.weight_3      = w3;
        r.radius        = signed'($urandom());
        for (int i = 0; i < 4; i++)
        begin
            b = idx[6*i +: 6];
            if (b < BONES && !bone_loaded[b])
                case (i)
                    0: r.weight_0 = '0;
                    1: r.weight_1 = '0;
                    2: r.weight_2 = '0;
                    default: r.weight_3 = '0;
                endcase
        end
        return r;
    endfunction

    // queue a load, and mark a bone loaded once all six of its words are queued
    task automatic queue_load(input int addr, input logic signed [31:0] v);
        pending_reqs.push_back(load_req(addr, v));
    endtask

    task automatic queue_bone(input int bone);
        for (int k = 0; k < 6; k++)
            queue_load(bone*6 + k, rand_word());
        bone_loaded[bone] = 1'b1;
    endtask

    // ---------------------------------------------------------- driver
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap      <= 0;
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
            // hold request
        end
        else
        begin
            if (in_ch.valid)
            begin
                // accepted this edge: update predictor
                if (in_ch.opcode == lbs_pkg::OP_SKIN)
                begin
                    expected_pts.push_back(skin_point(req_t'({in_ch.opcode,
                        in_ch.table_address, in_ch.table_value, in_ch.point_x,
                        in_ch.point_y, in_ch.bone_indices, in_ch.weight_0,
                        in_ch.weight_1, in_ch.weight_2, in_ch.weight_3, in_ch.radius})));
                    n_skins++;
                end
                else
                begin
                    if (in_ch.table_address < TBL_WORDS)
                        bone_words[in_ch.table_address] = in_ch.table_value;
                    n_loads++;
                end
            end
            if (in_gap > 0 || pending_reqs.size() == 0)
            begin
                in_ch.valid <= 1'b0;
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
            end
            else
            begin
                req_t r;
                r = pending_reqs.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.opcode        <= r.opcode;
                in_ch.table_address <= r.table_address;
                in_ch.table_value   <= r.table_value;
                in_ch.point_x       <= r.point_x;
                in_ch.point_y       <= r.point_y;
                in_ch.bone_indices  <= r.bone_indices;
                in_ch.weight_0      <= r.weight_0;
                in_ch.weight_1      <= r.weight_1;
                in_ch.weight_2      <= r.weight_2;
                in_ch.weight_3      <= r.weight_3;
                in_ch.radius        <= r.radius;
                in_gap <= burst_mode ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // ---------------------------------------------------------- monitor
    int out_gap;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_results++;
                if (expected_pts.size() == 0)
                    report_mismatch("unexpected result", out_ch.skinned_x, '0);
                else
                begin
                    lbs_pkg::res_t e;
                    e = expected_pts.pop_front();
                    if (out_ch.skinned_x !== e.skinned_x)
                        report_mismatch("skinned_x", out_ch.skinned_x, e.skinned_x);
                    if (out_ch.skinned_y !== e.skinned_y)
                        report_mismatch("skinned_y", out_ch.skinned_y, e.skinned_y);
                    if (out_ch.radius_out !== e.radius_out)
                        report_mismatch("radius_out", out_ch.radius_out, e.radius_out);
                end
            end
            // ready: draw a stall per result, burst mode keeps it high
            if (burst_mode)
                out_ch.ready <= 1'b1;
            else if (out_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                out_gap      <= out_gap - 1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                out_ch.ready <= 1'b0;
                out_gap      <= $urandom_range(0, 15);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------- APB
    task automatic apb_write(input logic [2:0] idx, input logic signed [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        world_m[idx] = v;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_ch.valid || expected_pts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_world(input logic signed [31:0] xx, input logic signed [31:0] yx,
                             input logic signed [31:0] xy, input logic signed [31:0] yy,
                             input logic signed [31:0] tx, input logic signed [31:0] ty);
        wait_idle();
        apb_write(lbs_pkg::REG_WORLD_XX, xx);
        apb_write(lbs_pkg::REG_WORLD_YX, yx);
        apb_write(lbs_pkg::REG_WORLD_XY, xy);
        apb_write(lbs_pkg::REG_WORLD_YY, yy);
        apb_write(lbs_pkg::REG_WORLD_TX, tx);
        apb_write(lbs_pkg::REG_WORLD_TY, ty);
    endtask

    // mostly valid skins over loaded bones, some reloads and out-of-range noise
    task automatic queue_random(input int count);
        int dice;
        for (int n = 0; n < count; n++)
        begin
            dice = $urandom_range(0, 99);
            if (dice < 8)
                queue_load($urandom_range(0, TBL_WORDS - 1), rand_word());
            else if (dice < 10)
                queue_load($urandom_range(TBL_WORDS, 511), rand_word());
            else
                pending_reqs.push_back(skin_req(24'($urandom()), rand_weight(),
                                                rand_weight(), rand_weight(),
                                                rand_weight()));
        end
    endtask

    // ---------------------------------------------------------- stimulus
    initial
    begin
        cycles = 0;
        n_errors = 0;
        n_skins = 0;
        n_loads = 0;
        n_results = 0;
        burst_mode = 1'b0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = lbs_pkg::OP_LOAD;
        in_ch.table_address = '0;
        in_ch.table_value = '0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.bone_indices = '0;
        in_ch.weight_0 = '0;
        in_ch.weight_1 = '0;
        in_ch.weight_2 = '0;
        in_ch.weight_3 = '0;
        in_ch.radius = '0;
        out_ch.ready = 1'b0;
        world_m = '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0};
        for (int b = 0; b < BONES; b++)
            bone_loaded[b] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity bone 0, extreme bone 63, all loaded bones
        for (int k = 0; k < 6; k++)
            queue_load(k, (k == 0 || k == 3) ? 32'sd65536 : 32'sd0);
        bone_loaded[0] = 1'b1;
        for (int k = 0; k < 6; k++)
            queue_load(63*6 + k, k[0] ? 32'sh80000000 : 32'sh7FFFFFFF);
        bone_loaded[63] = 1'b1;
        queue_load(400, 32'sh12345678);          // address past the table
        // identity single influence at full weight
        pending_reqs.push_back(skin_req({18'd0, 6'd0}, 17'd65536, 17'd0, 17'd0, 17'd0));
        // no influence at all
        pending_reqs.push_back(skin_req(24'd0, 17'd0, 17'd0, 17'd0, 17'd0));
        // weight above one and saturation on the extreme bone
        pending_reqs.push_back(skin_req({6'd0, 6'd0, 6'd0, 6'd63},
                                        17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
        // in-range bone indices only (64+ never fits 6 bits, so all valid)
        pending_reqs.push_back(skin_req({6'd63, 6'd0, 6'd63, 6'd0},
                                        17'd1, 17'd32768, 17'd65535, 17'd65536));

        // load every bone so random skins reach deep
        for (int b = 1; b < 63; b++)
            queue_bone(b);

        queue_random(200);
        // hold off until all results are back, then a stall-free burst
        wait_idle();
        burst_mode = 1'b1;
        queue_random(100);
        wait_idle();
        burst_mode = 1'b0;

        set_world(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                  32'sh7FFFFFFF, 32'sh80000000);
        queue_random(200);
        set_world(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                  32'sh80000000, 32'sh7FFFFFFF);
        queue_random(150);
        set_world(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        queue_random(80);
        set_world(rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word());
        queue_random(200);
        set_world(32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0);
        queue_random(80);

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d skin and %0d load requests, %0d results, six world settings",
                 n_skins, n_loads, n_results);
        $display("mismatches: %0d, leftover expectations: %0d",
                 n_errors, expected_pts.size());
        if (n_errors == 0 && expected_pts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[linear_blend_skin_point_2d_unit.f]
+incdir+sv
sv/lbs_pkg.sv
sv/lbs_if.sv
sv/lbs_ram.sv
sv/lbs_lane.sv
sv/lbs_merge.sv
sv/linear_blend_skin_point_2d_unit.sv
sv/lbs_checker.sv
sim/tb_linear_blend_skin_point_2d_unit.sv
